// ----- design/rfp_pkg.sv -----
package rfp_pkg;

    // Field widths fixed by the stream format
    localparam int BYTE_W    = 8;
    localparam int IN_LEN_W  = 16;
    localparam int SEQ_W     = 16;
    localparam int TS_W      = 32;
    localparam int MAXP_W    = 12;
    localparam int STEP_W    = 17;
    localparam int CFG_DATA_W = 17;
    localparam int LENGTH_BITS_DEF = 16;

    // Configuration register indexes
    localparam logic CFG_MAX_PAYLOAD = 1'b0;
    localparam logic CFG_TS_STEP     = 1'b1;

    localparam logic [MAXP_W-1:0] MAX_PAYLOAD_RST = 12'd1400;
    localparam logic [STEP_W-1:0] TS_STEP_RST     = 17'd3000;
    localparam logic [MAXP_W-1:0] MAX_PAYLOAD_MIN = 12'd2;

    // NAL header fields and FU-A codes
    localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;
    localparam logic [7:0] NAL_FNRI_MASK = 8'hE0;
    localparam logic [7:0] NAL_TYPE_FU_A = 8'd28;
    localparam logic [7:0] NAL_TYPE_SPS  = 8'd7;
    localparam logic [7:0] NAL_TYPE_PPS  = 8'd8;
    localparam logic [7:0] FU_S_BIT      = 8'h80;
    localparam logic [7:0] FU_E_BIT      = 8'h40;

    // Up to three result bytes caused by one input byte
    typedef struct packed {
        logic [1:0]              cnt;
        logic [2:0][BYTE_W-1:0]  data;
        logic [2:0]              first;
        logic [2:0]              last;
        logic [SEQ_W-1:0]        seq;
        logic [TS_W-1:0]         ts;
    } t_bundle;

endpackage

// ----- design/h264_rtp_fua_packetizer.sv -----
// The first result of an accepted byte enters the result buffer at the acceptance edge.
// Throughput: one input byte per cycle while the output is not stalled and each byte yields
// at most one payload byte; the first data byte of a fragment yields three bytes.
// A two-entry result buffer sets how far the input may run ahead of the output.
// Reset (synchronous, active low) clears the unit state, sequence number and timestamp, and
// returns max_payload to 1400 and timestamp_step to 3000.
module h264_rtp_fua_packetizer
    import rfp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration writes
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // Input NAL byte stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [23:0]           i_s_axis_tdata,   // [7:0] nal_byte, [23:8] unit_length
    input  logic                  i_s_axis_tuser,   // [0] unit_start
    // Output RTP payload stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [55:0]           o_m_axis_tdata,   // [7:0] out_byte, [23:8] sequence_res,
                                                    // [55:24] timestamp
    output logic                  o_m_axis_tlast,   // packet_last
    output logic [1:0]            o_m_axis_tuser    // [0] packet_first, [1] run_last
);

    // A request on the input side is taken whenever the result buffer has a free entry, so a
    // single finished result waiting at the output does not stop the next byte from being processed.
    logic    accept;
    logic    push;
    t_bundle bundle;
    logic    buf_ready;

    logic [BYTE_W-1:0] out_byte;
    logic              out_first;
    logic              out_last;
    logic              out_run_last;
    logic [SEQ_W-1:0]  out_seq;
    logic [TS_W-1:0]   out_ts;

    assign o_s_axis_tready = buf_ready;
    assign accept          = i_s_axis_tvalid && buf_ready;

    // The core keeps the per-unit state and turns each accepted byte into a bundle of up to
    // three payload bytes, inserting the FU indicator and FU header where a fragment opens.
    rfp_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_accept      (accept),
        .i_nal_byte    (i_s_axis_tdata[7:0]),
        .i_unit_start  (i_s_axis_tuser),
        .i_unit_length (i_s_axis_tdata[23:8]),
        .o_push        (push),
        .o_bundle      (bundle)
    );

    // The output buffer holds bundles and hands their bytes out one request at a time.
    rfp_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_bundle   (bundle),
        .o_ready    (buf_ready),
        .o_valid    (o_m_axis_tvalid),
        .i_take     (i_m_axis_tready),
        .o_byte     (out_byte),
        .o_first    (out_first),
        .o_last     (out_last),
        .o_run_last (out_run_last),
        .o_seq      (out_seq),
        .o_ts       (out_ts)
    );

    assign o_m_axis_tdata = {out_ts, out_seq, out_byte};
    assign o_m_axis_tlast = out_last;
    assign o_m_axis_tuser = {out_run_last, out_first};

endmodule

// ----- design/rfp_core.sv -----
module rfp_core
    import rfp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_accept,
    input  logic [BYTE_W-1:0]     i_nal_byte,
    input  logic                  i_unit_start,
    input  logic [IN_LEN_W-1:0]   i_unit_length,
    output logic                  o_push,
    output t_bundle               o_bundle
);

    localparam int LEN_W = (LENGTH_BITS < IN_LEN_W) ? LENGTH_BITS : IN_LEN_W;

    logic [MAXP_W-1:0] r_max_payload;
    logic [STEP_W-1:0] r_ts_step;
    logic [LEN_W-1:0]  r_left,  n_left;
    logic [7:0]        r_saved, n_saved;
    logic              r_mode,  n_mode;
    logic [MAXP_W-1:0] r_fill,  n_fill;
    logic              r_first_frag, n_first_frag;
    logic [SEQ_W-1:0]  r_seq,   n_seq;
    logic [TS_W-1:0]   r_ts,    n_ts;

    logic [MAXP_W-1:0] mp;
    logic [LEN_W-1:0]  len_in;
    logic [LEN_W-1:0]  len1;
    logic [MAXP_W-1:0] fill_inc;
    logic [7:0]        hdr_type;
    logic [7:0]        fu_hdr;
    logic              frag_last;

    assign mp = (r_max_payload < MAX_PAYLOAD_MIN) ? MAX_PAYLOAD_MIN : r_max_payload;
    assign len_in = i_unit_length[LEN_W-1:0];
    assign len1 = (len_in == '0) ? LEN_W'(1) : len_in;
    assign fill_inc = r_fill + MAXP_W'(1);

    always_comb begin
        n_left       = r_left;
        n_saved      = r_saved;
        n_mode       = r_mode;
        n_fill       = r_fill;
        n_first_frag = r_first_frag;
        n_seq        = r_seq;
        n_ts         = r_ts;
        o_push       = 1'b0;
        o_bundle     = '0;
        o_bundle.seq = r_seq;
        o_bundle.ts  = r_ts;
        hdr_type     = '0;
        fu_hdr       = '0;
        frag_last    = 1'b0;

        if (i_accept) begin
            if (i_unit_start) begin
                n_saved      = i_nal_byte;
                n_left       = len1 - LEN_W'(1);
                n_first_frag = 1'b1;
                n_fill       = '0;
                if (32'(len1) <= 32'(mp)) begin
                    n_mode            = 1'b0;
                    o_push            = 1'b1;
                    o_bundle.cnt      = 2'd1;
                    o_bundle.data[0]  = i_nal_byte;
                    o_bundle.first[0] = 1'b1;
                    o_bundle.last[0]  = (n_left == '0);
                    if (n_left == '0) begin
                        n_seq    = r_seq + SEQ_W'(1);
                        hdr_type = i_nal_byte & NAL_TYPE_MASK;
                        if (hdr_type != NAL_TYPE_SPS && hdr_type != NAL_TYPE_PPS) begin
                            n_ts = r_ts + TS_W'(r_ts_step);
                        end
                    end
                end else begin
                    n_mode = 1'b1;
                end
            end else if (r_left != '0) begin
                n_left = r_left - LEN_W'(1);
                if (!r_mode) begin
                    o_push            = 1'b1;
                    o_bundle.cnt      = 2'd1;
                    o_bundle.data[0]  = i_nal_byte;
                    o_bundle.last[0]  = (n_left == '0);
                    if (n_left == '0) begin
                        n_seq    = r_seq + SEQ_W'(1);
                        hdr_type = r_saved & NAL_TYPE_MASK;
                        if (hdr_type != NAL_TYPE_SPS && hdr_type != NAL_TYPE_PPS) begin
                            n_ts = r_ts + TS_W'(r_ts_step);
                        end
                    end
                end else begin
                    frag_last = (fill_inc >= mp) || (n_left == '0);
                    o_push    = 1'b1;
                    if (r_fill == '0) begin
                        // Fragment opens: FU indicator and FU header go first
                        fu_hdr = r_saved & NAL_TYPE_MASK;
                        if (r_first_frag) begin
                            fu_hdr = fu_hdr | FU_S_BIT;
                        end
                        if (32'(r_left) <= 32'(mp)) begin
                            fu_hdr = fu_hdr | FU_E_BIT;
                        end
                        o_bundle.cnt      = 2'd3;
                        o_bundle.data[0]  = (r_saved & NAL_FNRI_MASK) | NAL_TYPE_FU_A;
                        o_bundle.first[0] = 1'b1;
                        o_bundle.data[1]  = fu_hdr;
                        o_bundle.data[2]  = i_nal_byte;
                        o_bundle.last[2]  = frag_last;
                        n_first_frag      = 1'b0;
                    end else begin
                        o_bundle.cnt     = 2'd1;
                        o_bundle.data[0] = i_nal_byte;
                        o_bundle.last[0] = frag_last;
                    end
                    n_fill = frag_last ? '0 : fill_inc;
                    if (frag_last) begin
                        n_seq = r_seq + SEQ_W'(1);
                        if (n_left == '0) begin
                            n_ts = r_ts + TS_W'(r_ts_step);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
            r_ts_step     <= TS_STEP_RST;
            r_left        <= '0;
            r_saved       <= '0;
            r_mode        <= 1'b0;
            r_fill        <= '0;
            r_first_frag  <= 1'b0;
            r_seq         <= '0;
            r_ts          <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_wdata[MAXP_W-1:0];
                    CFG_TS_STEP:     r_ts_step     <= i_cfg_wdata[STEP_W-1:0];
                    default:         r_ts_step     <= r_ts_step;
                endcase
            end
            r_left       <= n_left;
            r_saved      <= n_saved;
            r_mode       <= n_mode;
            r_fill       <= n_fill;
            r_first_frag <= n_first_frag;
            r_seq        <= n_seq;
            r_ts         <= n_ts;
        end
    end

endmodule

// ----- design/rfp_outbuf.sv -----
module rfp_outbuf
    import rfp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  t_bundle                  i_bundle,
    output logic                     o_ready,
    output logic                     o_valid,
    input  logic                     i_take,
    output logic [BYTE_W-1:0]        o_byte,
    output logic                     o_first,
    output logic                     o_last,
    output logic                     o_run_last,
    output logic [SEQ_W-1:0]         o_seq,
    output logic [TS_W-1:0]          o_ts
);

    t_bundle    r_buf [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] r_idx;

    t_bundle    head;
    logic       head_done;
    logic       pop;

    assign head      = r_buf[r_rd_ptr];
    assign o_ready   = (r_count != 2'd2);
    assign o_valid   = (r_count != 2'd0);
    assign head_done = (r_idx == head.cnt - 2'd1);
    assign pop       = o_valid && i_take && head_done;

    assign o_byte     = head.data[r_idx];
    assign o_first    = head.first[r_idx];
    assign o_last     = head.last[r_idx];
    assign o_run_last = head_done;
    assign o_seq      = head.seq;
    assign o_ts       = head.ts;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
            r_idx    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
                r_idx    <= 2'd0;
            end else if (o_valid && i_take) begin
                r_idx <= r_idx + 2'd1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- test/rtp_payload_checker.sv -----
`timescale 1ns / 1ps

module rtp_payload_checker
    import rfp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_valid,
    input  logic                  i_s_ready,
    input  logic [23:0]           i_s_data,
    input  logic                  i_s_user,
    input  logic                  i_m_valid,
    input  logic                  i_m_ready,
    input  logic [55:0]           i_m_data,
    input  logic                  i_m_last,
    input  logic [1:0]            i_m_user,
    output int                    o_failures,
    output int                    o_pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] pay;
        logic              pkt_first;
        logic              pkt_last;
        logic [SEQ_W-1:0]  seq;
        logic [TS_W-1:0]   ts;
        logic              run_last;
    } t_payload_beat;

    t_payload_beat expected_beats[$];
    int fail_count = 0;

    // Register copies
    logic [MAXP_W-1:0] max_payload;
    logic [STEP_W-1:0] ts_step;

    // Unit state
    logic [IN_LEN_W-1:0] bytes_left;
    logic [7:0]          saved_header;
    logic                fragment_mode;
    logic [MAXP_W-1:0]   fragment_fill;
    logic                first_fragment;
    logic [SEQ_W-1:0]    seq_num;
    logic [TS_W-1:0]     ts_now;

    function automatic t_payload_beat make_beat(logic [7:0] b, logic f, logic l);
        t_payload_beat beat;
        beat.pay       = b;
        beat.pkt_first = f;
        beat.pkt_last  = l;
        beat.seq       = seq_num;
        beat.ts        = ts_now;
        beat.run_last  = 1'b0;
        return beat;
    endfunction

    // A single-packet unit closes its packet; parameter sets hold the timestamp.
    task automatic close_whole_unit(input logic [7:0] hdr);
        logic [7:0] nal_type;
        nal_type = hdr & NAL_TYPE_MASK;
        seq_num = seq_num + 1'b1;
        if (nal_type != NAL_TYPE_SPS && nal_type != NAL_TYPE_PPS)
            ts_now = ts_now + TS_W'(ts_step);
    endtask

    task automatic packetize_request(input logic [7:0] nal, input logic start,
                                     input logic [IN_LEN_W-1:0] len_field);
        logic [IN_LEN_W:0]  len;
        logic [MAXP_W-1:0]  mp;
        logic [7:0]         fu_hdr;
        logic               frag_done;
        t_payload_beat      step_beats[$];
        len = {1'b0, len_field};
        mp  = (max_payload < MAX_PAYLOAD_MIN) ? MAX_PAYLOAD_MIN : max_payload;
        if (start) begin
            if (len == 0)
                len = 1;
            saved_header   = nal;
            bytes_left     = IN_LEN_W'(len - 1);
            first_fragment = 1'b1;
            fragment_fill  = '0;
            if (len <= mp) begin
                fragment_mode = 1'b0;
                step_beats.push_back(make_beat(nal, 1'b1, bytes_left == 0));
                if (bytes_left == 0)
                    close_whole_unit(nal);
            end else begin
                fragment_mode = 1'b1;
            end
        end else if (bytes_left != 0) begin
            if (!fragment_mode) begin
                bytes_left = bytes_left - 1'b1;
                step_beats.push_back(make_beat(nal, 1'b0, bytes_left == 0));
                if (bytes_left == 0)
                    close_whole_unit(saved_header);
            end else begin
                if (fragment_fill == 0) begin
                    fu_hdr = saved_header & NAL_TYPE_MASK;
                    if (first_fragment)
                        fu_hdr = fu_hdr | FU_S_BIT;
                    if (bytes_left <= mp)
                        fu_hdr = fu_hdr | FU_E_BIT;
                    step_beats.push_back(make_beat((saved_header & NAL_FNRI_MASK) |
                                                   NAL_TYPE_FU_A, 1'b1, 1'b0));
                    step_beats.push_back(make_beat(fu_hdr, 1'b0, 1'b0));
                    first_fragment = 1'b0;
                end
                fragment_fill = fragment_fill + 1'b1;
                bytes_left    = bytes_left - 1'b1;
                frag_done     = (fragment_fill >= mp) || (bytes_left == 0);
                step_beats.push_back(make_beat(nal, 1'b0, frag_done));
                if (frag_done) begin
                    seq_num       = seq_num + 1'b1;
                    fragment_fill = '0;
                    if (bytes_left == 0)
                        ts_now = ts_now + TS_W'(ts_step);
                end
            end
        end
        if (step_beats.size() > 0)
            step_beats[step_beats.size() - 1].run_last = 1'b1;
        foreach (step_beats[k])
            expected_beats.push_back(step_beats[k]);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_payload_beat want;
        if (!i_rst_n) begin
            max_payload    = MAX_PAYLOAD_RST;
            ts_step        = TS_STEP_RST;
            bytes_left     = '0;
            saved_header   = '0;
            fragment_mode  = 1'b0;
            fragment_fill  = '0;
            first_fragment = 1'b0;
            seq_num        = '0;
            ts_now         = '0;
            expected_beats.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MAX_PAYLOAD: max_payload = i_cfg_wdata[MAXP_W-1:0];
                    CFG_TS_STEP:     ts_step     = i_cfg_wdata[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_valid && i_s_ready)
                packetize_request(i_s_data[7:0], i_s_user, i_s_data[23:8]);
            if (i_m_valid && i_m_ready) begin
                if (expected_beats.size() == 0) begin
                    $error("payload byte 0x%0h arrived with nothing expected", i_m_data[7:0]);
                    fail_count++;
                end else begin
                    want = expected_beats.pop_front();
                    compare_field("out_byte",     want.pay,       i_m_data[7:0]);
                    compare_field("packet_first", want.pkt_first, i_m_user[0]);
                    compare_field("packet_last",  want.pkt_last,  i_m_last);
                    compare_field("sequence_res", want.seq,       i_m_data[23:8]);
                    compare_field("timestamp",    want.ts,        i_m_data[55:24]);
                    compare_field("run_last",     want.run_last,  i_m_user[1]);
                end
            end
        end
        o_failures <= fail_count;
        o_pending  <= expected_beats.size();
    end

endmodule

// ----- test/tb_h264_rtp_fua_packetizer.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the FU-A packetiser. The checker instantiated beside
// the block follows every accepted request, predicts the payload bytes and
// compares them; this module only produces traffic and reads its tallies.
module tb_h264_rtp_fua_packetizer;
    import rfp_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic                  cfg_addr = CFG_MAX_PAYLOAD;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [23:0]           s_data = '0;
    logic                  s_user = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [55:0]           m_data;
    logic                  m_last;
    logic [1:0]            m_user;

    int failures;
    int pending;

    // When set, no new idling is drawn: back-to-back requests and a sink that
    // starts no new stalls, so that the block is also seen at full rate.
    bit calm = 1'b0;
    int stall_left = 0;
    int items_sent = 0;
    logic [MAXP_W-1:0] cur_max_payload = MAX_PAYLOAD_RST;

    h264_rtp_fua_packetizer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .o_m_axis_tuser  (m_user)
    );

    rtp_payload_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_s_valid   (s_valid),
        .i_s_ready   (s_ready),
        .i_s_data    (s_data),
        .i_s_user    (s_user),
        .i_m_valid   (m_valid),
        .i_m_ready   (m_ready),
        .i_m_data    (m_data),
        .i_m_last    (m_last),
        .i_m_user    (m_user),
        .o_failures  (failures),
        .o_pending   (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    function automatic int draw_stall();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // The sink: ready by default, with stalls of random length dropped in.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
                stall_left <= draw_stall();
        end
    end

    // Offers one byte request and returns once it has been taken. Valid is
    // left high, so the next request may follow in the very next cycle; it is
    // only lowered when a gap is to be inserted.
    task automatic send_byte(input logic [7:0] b, input logic start,
                             input logic [IN_LEN_W-1:0] len);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {len, b};
        s_user  <= start;
        @(posedge i_clk);
        while (!s_ready)
            @(posedge i_clk);
        items_sent++;
    endtask

    // Drains the block: the pending count is registered in the checker, so an
    // edge is allowed first for the last accepted request to be counted. The
    // extra cycles cover a header byte that produces nothing yet.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Both registers in consecutive cycles, while the block is idle.
    task automatic write_config(input logic [MAXP_W-1:0] mp, input logic [STEP_W-1:0] step);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_MAX_PAYLOAD;
        cfg_wdata <= CFG_DATA_W'(mp);
        @(posedge i_clk);
        cfg_addr  <= CFG_TS_STEP;
        cfg_wdata <= CFG_DATA_W'(step);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        cur_max_payload = mp;
    endtask

    // One NAL unit with random content. Most units are complete; some are cut
    // short by the next header, and a few carry a wild length so that the
    // high bits of the length field are exercised. A unit that must finish is
    // always delivered whole, so that the block is left closed.
    task automatic send_random_unit(input bit must_finish);
        int pick;
        int eff_mp;
        int hi;
        int len;
        int to_send;
        logic [7:0] hdr;
        pick   = $urandom_range(0, 99);
        eff_mp = int'((cur_max_payload < MAX_PAYLOAD_MIN) ? MAX_PAYLOAD_MIN : cur_max_payload);
        hdr    = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0: hdr[4:0] = NAL_TYPE_SPS[4:0];
            1: hdr[4:0] = NAL_TYPE_PPS[4:0];
            default: ;
        endcase
        if (!must_finish && pick < 6) begin
            send_byte(hdr, 1'b1, IN_LEN_W'($urandom_range(0, 65535)));
            repeat ($urandom_range(0, 3))
                send_byte(8'($urandom_range(0, 255)), 1'b0,
                          IN_LEN_W'($urandom_range(0, 65535)));
        end else begin
            hi = (3 * eff_mp + 2 < 48) ? 3 * eff_mp + 2 : 48;
            case ($urandom_range(0, 24))
                0, 1:    len = 1;
                2:       len = 0;
                3, 4:    len = int'($urandom_range(49, 120));
                default: len = int'($urandom_range(2, hi));
            endcase
            to_send = (len > 1) ? len - 1 : 0;
            if (!must_finish && pick < 16 && len > 1)
                to_send = int'($urandom_range(0, len - 2));
            send_byte(hdr, 1'b1, IN_LEN_W'(len));
            repeat (to_send)
                send_byte(8'($urandom_range(0, 255)), 1'b0,
                          IN_LEN_W'($urandom_range(0, 65535)));
            // Stray bytes are only stray once the unit is closed.
            if (to_send == ((len > 1) ? len - 1 : 0) && $urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 2))
                    send_byte(8'($urandom_range(0, 255)), 1'b0,
                              IN_LEN_W'($urandom_range(0, 65535)));
        end
    endtask

    initial begin
        int n_units;
        bit last_unit;
        logic [MAXP_W-1:0] mp;
        logic [STEP_W-1:0] step;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, first with the reset values of the registers.
        // A header-only unit, then a zero length that counts as header-only;
        // the second is an SPS, so the timestamp must hold.
        send_byte(8'h65, 1'b1, 16'd1);
        send_byte(8'h67, 1'b1, 16'd0);
        // A stray byte while no unit is open gives nothing.
        send_byte(8'hFF, 1'b0, 16'hFFFF);
        // A short PPS unit with extreme data bytes.
        send_byte(8'h68, 1'b1, 16'd3);
        send_byte(8'h00, 1'b0, 16'h0000);
        send_byte(8'hFF, 1'b0, 16'hFFFF);
        settle();

        // Smallest payload and largest step: a five-byte body is cut 2, 2, 1.
        write_config(12'd2, 17'd90000);
        send_byte(8'h87, 1'b1, 16'd6);
        for (int k = 1; k <= 5; k++)
            send_byte(8'(k * 8'h11), 1'b0, 16'h0000);
        // Two data bytes fit one fragment, which then carries both S and E.
        send_byte(8'h41, 1'b1, 16'd3);
        send_byte(8'h3C, 1'b0, 16'h5555);
        send_byte(8'hC3, 1'b0, 16'hAAAA);
        // The longest unit, abandoned part way through a fragment by the next
        // header: no last mark and no advance for the partial packet.
        send_byte(8'h00, 1'b1, 16'hFFFF);
        send_byte(8'hA5, 1'b0, 16'h0000);
        send_byte(8'h5A, 1'b0, 16'h0000);
        send_byte(8'hC3, 1'b0, 16'h0000);
        send_byte(8'hFF, 1'b1, 16'd1);
        settle();

        // A payload limit below two behaves as two; a zero step holds the time.
        write_config(12'd0, 17'd0);
        send_byte(8'h61, 1'b1, 16'd4);
        send_byte(8'h12, 1'b0, 16'h0000);
        send_byte(8'h34, 1'b0, 16'h0000);
        send_byte(8'h56, 1'b0, 16'h0000);
        settle();

        // Random phases, each with its own register settings and idling mode.
        // Once enough requests have gone out, the current unit is the last one.
        while (items_sent < 400) begin
            case ($urandom_range(0, 10))
                0:       mp = 12'd0;
                1:       mp = 12'd1;
                2:       mp = 12'd2;
                3:       mp = 12'd3;
                4:       mp = 12'd4095;
                5:       mp = MAX_PAYLOAD_RST;
                6:       mp = 12'd5;
                default: mp = MAXP_W'($urandom_range(2, 40));
            endcase
            case ($urandom_range(0, 5))
                0:       step = 17'd0;
                1:       step = 17'd90000;
                2:       step = TS_STEP_RST;
                default: step = STEP_W'($urandom_range(0, 90000));
            endcase
            write_config(mp, step);
            calm = ($urandom_range(0, 4) == 0);
            n_units = $urandom_range(3, 10);
            for (int u = 0; u < n_units; u++) begin
                last_unit = (u == n_units - 1) || (items_sent >= 400);
                send_random_unit(last_unit);
                if (last_unit)
                    break;
            end
            settle();
            calm = 1'b0;
        end

        repeat (16) @(posedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("tb_h264_rtp_fua_packetizer: PASS");
        end else begin
            $display("tb_h264_rtp_fua_packetizer: FAIL");
        end
        $finish;
    end

    // Far beyond the slowest correct run: a little over 400 requests, each
    // giving three bytes against the longest stalls.
    initial begin
        #10_000_000;
        $display("tb_h264_rtp_fua_packetizer: FAIL");
        $finish;
    end

endmodule
